### rtl/core/gtm_pkg.sv
// Shared types, constants and a helper function for the gradient magnitude block.
`default_nettype none
package gtm_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int LW_W      = 11;
	localparam int PIX_W     = 8;
	localparam int MAG_W     = 9;

	// Square root unit: radicand padded to an even width, one root bit per step
	localparam int RAD_W     = 2 * MAG_W;
	localparam int ROOT_STEPS = MAG_W;
	localparam int STEP_W    = $clog2(ROOT_STEPS + 1);
	localparam int REM_W     = MAG_W + 2;

	// Register reset values
	localparam logic [LW_W-1:0]  LINE_WIDTH_RST  = LW_W'(512);
	localparam logic [PIX_W-1:0] EDGE_THR_RST    = PIX_W'(10);
	localparam logic [PIX_W-1:0] FLAT_VALUE_RST  = PIX_W'(255);
	localparam logic [PIX_W-1:0] BIN_THR_RST     = PIX_W'(127);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_EDGE_THR   = 2'd1,
		REG_FLAT_VALUE = 2'd2,
		REG_BIN_THR    = 2'd3
	} reg_idx_t;

	// Forward difference next - cur, kept only if it exceeds the threshold
	function automatic logic [PIX_W-1:0] diff_thr(
		input logic [PIX_W-1:0] cur,
		input logic [PIX_W-1:0] nxt,
		input logic [PIX_W-1:0] thr,
		input logic [PIX_W-1:0] flat
	);
		logic signed [PIX_W:0] d;
		d = $signed({1'b0, nxt}) - $signed({1'b0, cur});
		if (d > $signed({1'b0, thr})) begin
			return d[PIX_W-1:0];
		end
		return flat;
	endfunction

endpackage
`default_nettype wire

### rtl/core/gtm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module gtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/thresholded_gradient_magnitude.sv
// Top level: thresholded forward-difference gradient magnitude over a raster pixel stream.
// Item handling: a first-row pixel is only stored in the row memory; a flush or last-column
// item passes through a row memory read state and a result state; an interior pixel
// also passes through a second row memory read and the 9-step bit-serial square root.
// One finished result may wait in the output register while the next item is taken.
// Reset clears control state and loads register defaults; the row memory is not cleared.
`default_nettype none
module thresholded_gradient_magnitude
	import gtm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [LW_W-1:0]   cfg_data,
	// pixel channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [PIX_W-1:0]  pixel,
	input  wire logic              flush,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [PIX_W-1:0]       dx,
	output logic [PIX_W-1:0]       dy,
	output logic [MAG_W-1:0]       magnitude,
	output logic                   binary,
	output logic                   row_end
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR,
		ST_NXT,
		ST_ROOT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [LW_W-1:0]   line_width_q;
	logic [PIX_W-1:0]  edge_thr_q;
	logic [PIX_W-1:0]  flat_value_q;
	logic [PIX_W-1:0]  bin_thr_q;

	logic [ADDR_W-1:0] column_q;
	logic              past_first_q;

	// item registers
	logic [PIX_W-1:0]  pix_q;
	logic              flush_q;
	logic              last_q;
	logic [ADDR_W-1:0] col_q;
	logic [PIX_W-1:0]  cur_q;

	// result under construction
	logic [PIX_W-1:0]  res_dx_q;
	logic [PIX_W-1:0]  res_dy_q;
	logic [MAG_W-1:0]  res_mag_q;
	logic              res_bin_q;
	logic              res_end_q;

	// square root unit
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [MAG_W-1:0]  root_q;
	logic [STEP_W-1:0] step_q;

	// row memory port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [PIX_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;

	logic [LW_W-1:0]   w_eff;
	logic [LW_W-1:0]   w_last;
	logic              is_last;
	logic              in_xfer;
	logic              out_free;

	logic [PIX_W-1:0]  nxt_dx;
	logic [PIX_W-1:0]  nxt_dy;
	logic [PIX_W-1:0]  last_dy;
	logic [2*PIX_W:0]  sum_sq;

	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              take;

	gtm_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// Clamp the row width and find the last column
	always_comb begin
		if (line_width_q < LW_W'(2)) begin
			w_eff = LW_W'(2);
		end else if (line_width_q > LW_W'(MAX_WIDTH)) begin
			w_eff = LW_W'(MAX_WIDTH);
		end else begin
			w_eff = line_width_q;
		end
		w_last  = w_eff - LW_W'(1);
		is_last = (LW_W'(column_q) >= w_last);
	end

	// Differences for the interior and last-column cases, and the squared sum for the interior case
	always_comb begin
		nxt_dx  = diff_thr(cur_q, ram_rdata, edge_thr_q, flat_value_q);
		nxt_dy  = diff_thr(cur_q, pix_q, edge_thr_q, flat_value_q);
		last_dy = diff_thr(ram_rdata, pix_q, edge_thr_q, flat_value_q);
		sum_sq  = (2*PIX_W+1)'(nxt_dx) * (2*PIX_W+1)'(nxt_dx) +
			(2*PIX_W+1)'(nxt_dy) * (2*PIX_W+1)'(nxt_dy);
	end

	// One square root digit: bring down two radicand bits and try a one
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = (REM_W+2)'({root_q, 2'b01});
		take   = (rem_sh >= trial);
	end

	// Row memory addressing and write back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = col_q;
		ram_wdata = pix_q;
		ram_raddr = col_q;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = column_q;
				if (in_xfer && !flush && !past_first_q) begin
					ram_we    = 1'b1;
					ram_waddr = column_q;
					ram_wdata = pixel;
				end
			end
			ST_CUR: begin
				ram_raddr = col_q + ADDR_W'(1);
			end
			ST_EMIT: begin
				ram_we = out_free && !flush_q;
			end
			default: begin
				ram_raddr = col_q;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			edge_thr_q   <= EDGE_THR_RST;
			flat_value_q <= FLAT_VALUE_RST;
			bin_thr_q    <= BIN_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				REG_EDGE_THR:   edge_thr_q   <= cfg_data[PIX_W-1:0];
				REG_FLAT_VALUE: flat_value_q <= cfg_data[PIX_W-1:0];
				REG_BIN_THR:    bin_thr_q    <= cfg_data[PIX_W-1:0];
				default:        line_width_q <= line_width_q;
			endcase
		end
	end

	// Sequencer, position state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			column_q     <= '0;
			past_first_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			// drop the result once the sink takes it, unless a new one replaces it
			if (out_valid && !out_stall && state_q != ST_EMIT) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (past_first_q || !flush)) begin
						pix_q   <= pixel;
						flush_q <= flush;
						last_q  <= is_last;
						col_q   <= column_q;
						// advance the column
						column_q <= is_last ? '0 : column_q + ADDR_W'(1);
						if (!past_first_q) begin
							// first row: store only
							if (is_last) begin
								past_first_q <= 1'b1;
							end
						end else begin
							if (flush && is_last) begin
								past_first_q <= 1'b0;
							end
							state_q <= ST_CUR;
						end
					end
				end
				ST_CUR: begin
					cur_q     <= ram_rdata;
					res_bin_q <= (ram_rdata >= bin_thr_q);
					res_end_q <= last_q;
					res_dx_q  <= ram_rdata;
					res_mag_q <= MAG_W'(ram_rdata);
					if (flush_q) begin
						res_dy_q <= ram_rdata;
						state_q  <= ST_EMIT;
					end else if (last_q) begin
						res_dy_q <= last_dy;
						state_q  <= ST_EMIT;
					end else begin
						state_q <= ST_NXT;
					end
				end
				ST_NXT: begin
					res_dx_q <= nxt_dx;
					res_dy_q <= nxt_dy;
					rad_q    <= RAD_W'(sum_sq);
					rem_q    <= '0;
					root_q   <= '0;
					step_q   <= '0;
					state_q  <= ST_ROOT;
				end
				ST_ROOT: begin
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					rem_q  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
					root_q <= {root_q[MAG_W-2:0], take};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
						res_mag_q <= {root_q[MAG_W-2:0], take};
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid <= 1'b1;
						dx        <= res_dx_q;
						dy        <= res_dy_q;
						magnitude <= res_mag_q;
						binary    <= res_bin_q;
						row_end   <= res_end_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
